/* sv/epoch_seconds_to_rtc_calendar_macros.svh */
// Assertion helpers for the calendar converter.
`ifndef EPOCH_SECONDS_TO_RTC_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_RTC_CALENDAR_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset.
`define ECAL_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ecal assertion failed");
// Checked on every rising clock edge, reset included.
`define ECAL_ASSERT_RESET(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("ecal reset assertion failed");
`else
`define ECAL_ASSERT(label, prop)
`define ECAL_ASSERT_RESET(label, prop)
`endif

`endif

/* sv/ecal_pkg.sv */
package ecal_pkg;

   // pipeline layout
   localparam int STAGES    = 12;
   localparam int STG_SUM   = 0;   // shifted seconds
   localparam int STG_MUL   = 1;   // reciprocal product for the day split
   localparam int STG_REM   = 2;   // raw quotient and remainder
   localparam int STG_DAYS  = 3;   // corrected day count and second of day
   localparam int STG_CONV  = 4;   // first stage of the date and time paths
   localparam int STG_OUT   = STAGES - 1;

   // field widths
   localparam int EPOCH_W   = 34;
   localparam int TZ_W      = 5;
   localparam int SHIFT_W   = 35;
   localparam int DAYS_W    = 18;
   localparam int SOD_W     = 17;
   localparam int LO_BITS   = 7;   // 86400 = 2^7 * 675

   // time constants
   localparam int SECS_PER_HOUR = 3600;
   localparam int DAY_BIAS      = 86400;  // keeps the shifted time positive
   localparam int DAY_ODD       = 675;
   localparam int NOON_HOUR     = 12;
   localparam int WEEK_SHIFT    = 3;      // biased day 0 is a Wednesday

   // calendar constants
   localparam int CIVIL_SHIFT   = 719467; // biased day to days since 0000-03-01
   localparam int ERA_DAYS      = 146097;
   localparam int ERA_MAX       = 6;
   localparam int CENT_DAYS     = 36524;
   localparam int BASE_YEAR     = 2000;
   localparam int CENTURY_YEARS = 100;
   localparam int ERA_YEARS     = 400;

   // reciprocals: floor(x / d) = (x * R) >> S over the value ranges used here
   localparam int RECIP_DAY_SHIFT = 38;
   localparam longint unsigned RECIP_DAY = (64'd1 << RECIP_DAY_SHIFT) / 64'd675;
   localparam int RECIP_60  = ((1 << 23) + 59) / 60;     // shift 23
   localparam int RECIP_7   = ((1 << 21) + 6) / 7;       // shift 21
   localparam int RECIP_365 = ((1 << 24) + 364) / 365;   // shift 24
   localparam int RECIP_100 = ((1 << 12) + 99) / 100;    // shift 12
   localparam int RECIP_153 = ((1 << 18) + 152) / 153;   // shift 18

   typedef struct packed {
      logic [DAYS_W-1:0] days_b;  // day count plus one
      logic [SOD_W-1:0]  sod;
   } split_type;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic       is_pm;
      logic [2:0] weekday;
   } tod_type;

   typedef struct packed {
      logic [4:0] day_of_month;
      logic [3:0] month_number;
      logic [6:0] year_of_century;
      logic       range_error;
   } date_type;

   // first day of each month, counted from March 1
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] r;
      unique case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

/* sv/ecal_split.sv */
module ecal_split import ecal_pkg::*; (
   input  logic                   clock,
   input  logic [STAGES-1:0]      load,
   input  logic signed [TZ_W-1:0] tz_offset,
   input  logic [EPOCH_W-1:0]     epoch_seconds,
   output split_type              split_out
);

   logic signed [18:0]   bias;
   logic [SHIFT_W-1:0]   shifted_in, shifted_ff;
   logic [27:0]          coarse_ff;
   logic [56:0]          prod_in, prod_ff;
   logic [LO_BITS-1:0]   lo_mul_ff, lo_rem_ff;
   logic [18:0]          quot_in, quot_ff;
   logic [27:0]          rem_wide;
   logic [10:0]          rem_in, rem_ff;
   logic [DAYS_W-1:0]    days_in;
   logic [9:0]           rem_fix;
   split_type            split_in, split_ff;

   // offset plus one day: always positive for any legal word
   always_comb begin
      bias       = 19'(DAY_BIAS) + 19'(tz_offset) * 19'(SECS_PER_HOUR);
      shifted_in = SHIFT_W'(epoch_seconds) + SHIFT_W'(bias[17:0]);
   end

   assign prod_in = 57'(shifted_ff[SHIFT_W-1:LO_BITS]) * 57'(RECIP_DAY);

   // quotient may be one short; remainder then lands in [675, 1350)
   always_comb begin
      quot_in  = prod_ff[56:RECIP_DAY_SHIFT];
      rem_wide = coarse_ff - 28'(quot_in) * 28'(DAY_ODD);
      rem_in   = rem_wide[10:0];
   end

   always_comb begin
      if (rem_ff >= 11'(DAY_ODD)) begin
         days_in = DAYS_W'(quot_ff + 19'd1);
         rem_fix = 10'(rem_ff - 11'(DAY_ODD));
      end else begin
         days_in = quot_ff[DAYS_W-1:0];
         rem_fix = rem_ff[9:0];
      end
      split_in.days_b = days_in;
      split_in.sod    = {rem_fix, lo_rem_ff};
   end

   always_ff @(posedge clock) begin
      if (load[STG_SUM]) begin
         shifted_ff <= shifted_in;
      end
      if (load[STG_MUL]) begin
         prod_ff   <= prod_in;
         coarse_ff <= shifted_ff[SHIFT_W-1:LO_BITS];
         lo_mul_ff <= shifted_ff[LO_BITS-1:0];
      end
      if (load[STG_REM]) begin
         quot_ff   <= quot_in;
         rem_ff    <= rem_in;
         lo_rem_ff <= lo_mul_ff;
      end
      if (load[STG_DAYS]) begin
         split_ff <= split_in;
      end
   end

   assign split_out = split_ff;

endmodule

/* sv/ecal_tod.sv */
module ecal_tod import ecal_pkg::*; (
   input  logic              clock,
   input  logic [STAGES-1:0] load,
   input  split_type         split_in,
   output tod_type           tod_out
);

   logic [34:0]       mt_prod;
   logic [10:0]       mt_in, mt_ff, mt5_ff;
   logic [SOD_W-1:0]  sod_ff;
   logic [DAYS_W-1:0] wk_base_in, wk_base_ff;
   logic [36:0]       wk_prod;
   logic [15:0]       wq_in, wq_ff;
   logic [5:0]        sec_in, sec5_ff;
   logic [28:0]       hr_prod;
   logic [4:0]        hour_in, hour5_ff;
   logic [2:0]        wd_in, wd5_ff;
   tod_type           tod_in;
   tod_type           pipe_ff [STG_CONV+2:STG_OUT];

   // minutes of day and week quotient
   always_comb begin
      mt_prod    = 35'(split_in.sod) * 35'(RECIP_60);
      mt_in      = mt_prod[33:23];
      wk_base_in = split_in.days_b + DAYS_W'(WEEK_SHIFT);
      wk_prod    = 37'(wk_base_in) * 37'(RECIP_7);
      wq_in      = wk_prod[36:21];
   end

   always_comb begin
      sec_in  = 6'(sod_ff - 17'(mt_ff) * 17'(60));
      hr_prod = 29'(mt_ff) * 29'(RECIP_60);
      hour_in = hr_prod[27:23];
      wd_in   = 3'(wk_base_ff - DAYS_W'(wq_ff) * DAYS_W'(7));
   end

   always_comb begin
      tod_in.second  = sec5_ff;
      tod_in.minute  = 6'(mt5_ff - 11'(hour5_ff) * 11'(60));
      tod_in.hour    = hour5_ff;
      tod_in.is_pm   = (hour5_ff >= 5'(NOON_HOUR));
      tod_in.weekday = wd5_ff;
   end

   always_ff @(posedge clock) begin
      if (load[STG_CONV]) begin
         mt_ff      <= mt_in;
         sod_ff     <= split_in.sod;
         wk_base_ff <= wk_base_in;
         wq_ff      <= wq_in;
      end
      if (load[STG_CONV+1]) begin
         sec5_ff  <= sec_in;
         hour5_ff <= hour_in;
         mt5_ff   <= mt_ff;
         wd5_ff   <= wd_in;
      end
      if (load[STG_CONV+2]) begin
         pipe_ff[STG_CONV+2] <= tod_in;
      end
      // wait for the date path
      for (int i = STG_CONV + 3; i <= STG_OUT; i++) begin
         if (load[i]) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   assign tod_out = pipe_ff[STG_OUT];

endmodule

/* sv/ecal_civil.sv */
module ecal_civil import ecal_pkg::*; (
   input  logic              clock,
   input  logic [STAGES-1:0] load,
   input  logic [DAYS_W-1:0] days_b,
   output date_type          date_out
);

   logic [19:0] z;
   logic [19:0] era_base;
   logic [2:0]  era_in;
   logic [17:0] doe_in;
   logic [2:0]  era4_ff, era5_ff, era6_ff, era7_ff, era8_ff, era9_ff, era10_ff;
   logic [17:0] doe4_ff, doe5_ff, doe6_ff, doe7_ff, doe8_ff;
   logic [31:0] frac_prod;
   logic [7:0]  quad_in, quad_ff;
   logic [2:0]  cent_in, cent_ff;
   logic        last_in, last_ff;
   logic [17:0] num_in, num_ff;
   logic [33:0] yoe_prod;
   logic [8:0]  yoe_in, yoe7_ff, yoe8_ff, yoe9_ff, yoe10_ff;
   logic [13:0] yc_prod;
   logic [1:0]  yc_in, yc_ff;
   logic [8:0]  doy_in, doy9_ff, doy10_ff;
   logic [10:0] mp_arg;
   logic [21:0] mp_prod;
   logic [3:0]  mp_in, mp_ff;
   logic [3:0]  month;
   logic [11:0] year;
   logic        bad;
   date_type    date_in, date_ff;

   // era of 400 years: at most six boundaries to test
   always_comb begin
      z        = 20'(days_b) + 20'(CIVIL_SHIFT);
      era_in   = '0;
      era_base = '0;
      for (int e = 1; e <= ERA_MAX; e++) begin
         if (z >= 20'(e * ERA_DAYS)) begin
            era_in   = 3'(e);
            era_base = 20'(e * ERA_DAYS);
         end
      end
      doe_in = 18'(z - era_base);
   end

   // leap corrections: doe/1460, doe/36524, doe/146096
   always_comb begin
      frac_prod = 32'(doe4_ff[17:2]) * 32'(RECIP_365);
      quad_in   = frac_prod[31:24];
      cent_in   = '0;
      for (int k = 1; k <= 4; k++) begin
         if (doe4_ff >= 18'(k * CENT_DAYS)) begin
            cent_in = 3'(k);
         end
      end
      last_in = (doe4_ff == 18'(ERA_DAYS - 1));
   end

   assign num_in = doe5_ff - 18'(quad_ff) + 18'(cent_ff) - 18'(last_ff);

   always_comb begin
      yoe_prod = 34'(num_ff) * 34'(RECIP_365);
      yoe_in   = yoe_prod[32:24];
   end

   always_comb begin
      yc_prod = 14'(yoe7_ff) * 14'(RECIP_100);
      yc_in   = yc_prod[13:12];
   end

   assign doy_in = 9'(doe8_ff - (18'(yoe8_ff) * 18'(365) + 18'(yoe8_ff[8:2]) - 18'(yc_ff)));

   always_comb begin
      mp_arg  = 11'(doy9_ff) * 11'(5) + 11'd2;
      mp_prod = 22'(mp_arg) * 22'(RECIP_153);
      mp_in   = mp_prod[21:18];
   end

   // March-based month back to January-based, year bumps for Jan and Feb
   always_comb begin
      month = (mp_ff < 4'd10) ? mp_ff + 4'd3 : mp_ff - 4'd9;
      year  = 12'(era10_ff) * 12'(ERA_YEARS) + 12'(yoe10_ff) + 12'(month <= 4'd2);
      bad   = (year < 12'(BASE_YEAR)) || (year >= 12'(BASE_YEAR + CENTURY_YEARS));
      date_in.day_of_month    = 5'(doy10_ff - month_start(mp_ff) + 9'd1);
      date_in.month_number    = month;
      date_in.year_of_century = bad ? 7'd0 : 7'(year - 12'(BASE_YEAR));
      date_in.range_error     = bad;
   end

   always_ff @(posedge clock) begin
      if (load[STG_CONV]) begin
         era4_ff <= era_in;
         doe4_ff <= doe_in;
      end
      if (load[STG_CONV+1]) begin
         era5_ff <= era4_ff;
         doe5_ff <= doe4_ff;
         quad_ff <= quad_in;
         cent_ff <= cent_in;
         last_ff <= last_in;
      end
      if (load[STG_CONV+2]) begin
         era6_ff <= era5_ff;
         doe6_ff <= doe5_ff;
         num_ff  <= num_in;
      end
      if (load[STG_CONV+3]) begin
         era7_ff <= era6_ff;
         doe7_ff <= doe6_ff;
         yoe7_ff <= yoe_in;
      end
      if (load[STG_CONV+4]) begin
         era8_ff <= era7_ff;
         doe8_ff <= doe7_ff;
         yoe8_ff <= yoe7_ff;
         yc_ff   <= yc_in;
      end
      if (load[STG_CONV+5]) begin
         era9_ff <= era8_ff;
         yoe9_ff <= yoe8_ff;
         doy9_ff <= doy_in;
      end
      if (load[STG_CONV+6]) begin
         era10_ff <= era9_ff;
         yoe10_ff <= yoe9_ff;
         doy10_ff <= doy9_ff;
         mp_ff    <= mp_in;
      end
      if (load[STG_OUT]) begin
         date_ff <= date_in;
      end
   end

   assign date_out = date_ff;

endmodule

/* sv/epoch_seconds_to_rtc_calendar.sv */
// Throughput: one word per cycle while rsp is not stalled; every stage is a register,
// and a full stage moves on only when the stage after it takes its word.
// A stall on rsp backs up only through full stages; bubbles are squeezed out.
// Reset (synchronous) empties the pipeline and sets the time-zone offset to 0.
// The csr port is always ready; write it only while the pipeline is empty.
`include "epoch_seconds_to_rtc_calendar_macros.svh"

module epoch_seconds_to_rtc_calendar import ecal_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [EPOCH_W-1:0]     req_epoch_seconds,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [5:0]             rsp_second,
   output logic [5:0]             rsp_minute,
   output logic [4:0]             rsp_hour,
   output logic                   rsp_is_pm,
   output logic [2:0]             rsp_weekday,
   output logic [4:0]             rsp_day_of_month,
   output logic [3:0]             rsp_month_number,
   output logic [6:0]             rsp_year_of_century,
   output logic                   rsp_range_error,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic signed [TZ_W-1:0] csr_tz_offset_hours
);

   logic signed [TZ_W-1:0] tz_offset_ff;
   logic [STAGES-1:0]      valid_in, valid_ff;
   logic [STAGES-1:0]      ready;
   split_type              split_word;
   tod_type                tod_word;
   date_type               date_word;

   // Stage map:
   //   0      shifted = epoch + 3600*tz + 86400 (bias keeps it positive)
   //   1..3   divide by 86400 = 2^7 * 675: reciprocal multiply, then one
   //          compare-and-subtract fixes a quotient that came out one short
   //   4..6   second of day -> h/m/s, day count -> weekday (time path)
   //   4..11  day count -> era, day of era, year of era, day of year,
   //          month, day and year check (date path)
   // The time path waits in a short delay line so both paths meet at stage 11,
   // which is the output register.

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tz_offset_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         tz_offset_ff <= csr_tz_offset_hours;
      end
   end

   // Each stage takes a new word (or a bubble) when it is empty or when the
   // stage after it is taking its word this cycle.
   always_comb begin
      ready[STG_OUT] = !valid_ff[STG_OUT] || !rsp_stall;
      for (int i = STG_OUT - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      if (ready[0]) begin
         valid_in[0] = req_valid;
      end else begin
         valid_in[0] = valid_ff[0];
      end
      for (int i = 1; i < STAGES; i++) begin
         if (ready[i]) begin
            valid_in[i] = valid_ff[i-1];
         end else begin
            valid_in[i] = valid_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !ready[0];

   ecal_split u_split (
      .clock         (clock),
      .load          (ready),
      .tz_offset     (tz_offset_ff),
      .epoch_seconds (req_epoch_seconds),
      .split_out     (split_word)
   );

   ecal_tod u_tod (
      .clock    (clock),
      .load     (ready),
      .split_in (split_word),
      .tod_out  (tod_word)
   );

   ecal_civil u_civil (
      .clock    (clock),
      .load     (ready),
      .days_b   (split_word.days_b),
      .date_out (date_word)
   );

   assign rsp_valid           = valid_ff[STG_OUT];
   assign rsp_second          = tod_word.second;
   assign rsp_minute          = tod_word.minute;
   assign rsp_hour            = tod_word.hour;
   assign rsp_is_pm           = tod_word.is_pm;
   assign rsp_weekday         = tod_word.weekday;
   assign rsp_day_of_month    = date_word.day_of_month;
   assign rsp_month_number    = date_word.month_number;
   assign rsp_year_of_century = date_word.year_of_century;
   assign rsp_range_error     = date_word.range_error;

   // calendar fields all inside their legal ranges
   function automatic logic fields_legal(tod_type t, date_type d);
      return (t.second < 6'd60) && (t.minute < 6'd60) && (t.hour < 5'd24) &&
             (t.weekday < 3'd7) && (d.day_of_month != 5'd0) &&
             (d.month_number != 4'd0) && (d.month_number < 4'd13) &&
             (d.year_of_century < 7'd100);
   endfunction

   // req is held back only when no stage has room
   `ECAL_ASSERT(a_stall_only_when_full, req_stall |-> (&valid_ff))

   // every delivered word carries calendar fields in their legal ranges
   `ECAL_ASSERT(a_fields_in_range, rsp_valid |-> fields_legal(tod_word, date_word))

   // reset leaves nothing to deliver and room to accept
   `ECAL_ASSERT_RESET(a_empty_after_reset, reset |=> (!rsp_valid && !req_stall))

endmodule
